/* rtl/core/set_assoc_cache_random_replace_assert.svh */
// Assertion macros shared by the cache checker.
// Expects clk_i and rst_ni in the scope of each use.
`ifndef SET_ASSOC_CACHE_RANDOM_REPLACE_ASSERT_SVH
`define SET_ASSOC_CACHE_RANDOM_REPLACE_ASSERT_SVH

// same-cycle implication
`define SACRR_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("cache port check failed");

// next-cycle implication
`define SACRR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("cache port check failed");

`endif

/* rtl/core/sacrr_pkg.sv */
// Shared types and constants of the set-associative cache.
// No dependencies; used by every module of the block except sacrr_tag_store.
`timescale 1ns / 1ps

package sacrr_pkg;

  // fixed field widths
  localparam int DATA_W    = 32;
  localparam int ADDR_W    = 32;
  localparam int KIND_W    = 2;
  localparam int WAY_OUT_W = 3;
  localparam int LFSR_W    = 16;
  localparam int PADDR_W   = 3;

  // victim lfsr
  localparam logic [LFSR_W-1:0] LFSR_TAPS  = 16'hB400;
  localparam logic [LFSR_W-1:0] SEED_RESET = 16'd44257;

  // register index, taken from paddr[2]
  localparam logic REG_RANDOM_SEED = 1'b0;

  // item kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_READ   = 2'd0,
    KIND_WRITE  = 2'd1,
    KIND_REFILL = 2'd2
  } kind_e;

  // lfsr control from the cache controller
  typedef struct packed {
    logic              load;
    logic              step;
    logic [LFSR_W-1:0] seed;
  } lfsr_ctrl_t;

endpackage

/* rtl/core/sacrr_tag_store.sv */
// Tag memory: one row per set, holding valid bit and tag of every way.
// Synchronous registered read; depends on nothing else.
`timescale 1ns / 1ps

module sacrr_tag_store #(
  parameter int SETS  = 64,
  parameter int WAYS  = 8,
  parameter int TAG_W = 20
) (
  input  logic                           clk_i,
  input  logic                           rd_en_i,
  input  logic [$clog2(SETS)-1:0]        rd_set_i,
  output logic [WAYS-1:0][TAG_W:0]       rd_row_o,
  input  logic                           wr_en_i,
  input  logic [$clog2(SETS)-1:0]        wr_set_i,
  input  logic [WAYS-1:0][TAG_W:0]       wr_row_i
);

  logic [WAYS-1:0][TAG_W:0] mem [SETS];
  logic [WAYS-1:0][TAG_W:0] row_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_set_i] <= wr_row_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      row_q <= mem[rd_set_i];
    end
  end

  assign rd_row_o = row_q;

endmodule

/* rtl/core/sacrr_data_store.sv */
// Data memory: one row per set and word offset, one 32-bit lane per way.
// Synchronous registered read; uses sacrr_pkg for widths.
`timescale 1ns / 1ps

module sacrr_data_store #(
  parameter int DEPTH = 1024,
  parameter int WAYS  = 8
) (
  input  logic                                 clk_i,
  input  logic                                 rd_en_i,
  input  logic [$clog2(DEPTH)-1:0]             rd_idx_i,
  output logic [WAYS-1:0][sacrr_pkg::DATA_W-1:0] rd_row_o,
  input  logic                                 wr_en_i,
  input  logic [$clog2(DEPTH)-1:0]             wr_idx_i,
  input  logic [((WAYS > 1) ? $clog2(WAYS) : 1)-1:0] wr_lane_i,
  input  logic [sacrr_pkg::DATA_W-1:0]         wr_data_i
);

  logic [WAYS-1:0][sacrr_pkg::DATA_W-1:0] mem [DEPTH];
  logic [WAYS-1:0][sacrr_pkg::DATA_W-1:0] row_q;

  // lane write
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_idx_i][wr_lane_i] <= wr_data_i;
    end
  end

  // registered row read
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      row_q <= mem[rd_idx_i];
    end
  end

  assign rd_row_o = row_q;

endmodule

/* rtl/core/sacrr_lfsr.sv */
// Victim LFSR: 16-bit Galois right-shift register, loadable with a seed.
// Uses sacrr_pkg for the tap mask, reset seed and control struct.
`timescale 1ns / 1ps

module sacrr_lfsr (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  sacrr_pkg::lfsr_ctrl_t         ctrl_i,
  output logic [sacrr_pkg::LFSR_W-1:0]  next_o
);

  logic [sacrr_pkg::LFSR_W-1:0] state_q;
  logic [sacrr_pkg::LFSR_W-1:0] state_d;

  // one shift step, taps applied when the bit shifted out is set
  assign next_o = (state_q >> 1) ^ (state_q[0] ? sacrr_pkg::LFSR_TAPS : '0);

  always_comb begin
    state_d = state_q;
    if (ctrl_i.load) begin
      state_d = ctrl_i.seed;
    end else if (ctrl_i.step) begin
      state_d = next_o;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sacrr_pkg::SEED_RESET;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* rtl/core/set_assoc_cache_random_replace.sv */
// Top level of the set-associative cache with random replacement.
// Uses sacrr_pkg, sacrr_tag_store, sacrr_data_store and sacrr_lfsr.
`timescale 1ns / 1ps

// Tag and data rows are read from synchronous memories at the edge that
// accepts a word. Tags are compared and the rows written back when the
// result is registered; this waits while out_stall_i holds an earlier
// result. Until then in_stall_o is high, so no new word is taken before
// the last one is written back. A new word is taken while a finished
// result still waits. Valid bits live in the tag rows and are qualified by
// one flip-flop per set that reset clears, so there is no clearing pass
// after reset. The user must keep SETS, WORDS_PER_LINE and WAYS powers of
// two; the block itself does not enforce it. Data words never written since
// reset read back undefined.
module set_assoc_cache_random_replace #(
  parameter int SETS           = 64,
  parameter int WAYS           = 8,
  parameter int WORDS_PER_LINE = 16,
  parameter int ADDR_BITS      = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // input words
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [sacrr_pkg::KIND_W-1:0]    kind_i,
  input  logic [sacrr_pkg::ADDR_W-1:0]    address_i,
  input  logic [sacrr_pkg::DATA_W-1:0]    data_i,
  // result words
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            hit_o,
  output logic [sacrr_pkg::WAY_OUT_W-1:0] way_o,
  output logic                            evicted_o,
  output logic [sacrr_pkg::DATA_W-1:0]    read_data_o,
  // configuration port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [sacrr_pkg::PADDR_W-1:0]   paddr,
  input  logic [sacrr_pkg::DATA_W-1:0]    pwdata,
  output logic [sacrr_pkg::DATA_W-1:0]    prdata,
  output logic                            pready
);

  localparam int SET_BITS  = $clog2(SETS);
  localparam int OFF_BITS  = $clog2(WORDS_PER_LINE);
  localparam int WAY_BITS  = $clog2(WAYS);
  localparam int WORD_W    = (OFF_BITS > 0) ? OFF_BITS : 1;
  localparam int WAY_W     = (WAY_BITS > 0) ? WAY_BITS : 1;
  localparam int EFF_ADDR  = (ADDR_BITS < sacrr_pkg::ADDR_W) ? ADDR_BITS : sacrr_pkg::ADDR_W;
  localparam int TAG_SHIFT = 2 + OFF_BITS + SET_BITS;
  localparam int TAG_W     = (EFF_ADDR > TAG_SHIFT) ? EFF_ADDR - TAG_SHIFT : 1;
  localparam int IDX_W     = SET_BITS + OFF_BITS;
  localparam int DEPTH     = SETS * WORDS_PER_LINE;

  localparam logic [sacrr_pkg::ADDR_W-1:0] ADDR_MASK =
    sacrr_pkg::ADDR_W'((64'd1 << EFF_ADDR) - 64'd1);
  localparam logic [sacrr_pkg::ADDR_W-1:0] WORD_MASK =
    sacrr_pkg::ADDR_W'(WORDS_PER_LINE - 1);
  localparam logic [sacrr_pkg::LFSR_W-1:0] WAY_MASK =
    sacrr_pkg::LFSR_W'(WAYS - 1);

  // handshake and control
  logic in_accept;
  logic busy_q;
  logic complete;
  logic out_valid_q;
  logic cfg_we;

  // address split of the incoming word
  logic [sacrr_pkg::ADDR_W-1:0] addr_m;
  logic [SET_BITS-1:0]          set_in;
  logic [WORD_W-1:0]            word_in;
  logic [TAG_W-1:0]             tag_in;

  // captured word
  logic [sacrr_pkg::KIND_W-1:0] kind_q;
  logic [SET_BITS-1:0]          set_q;
  logic [WORD_W-1:0]            word_q;
  logic [TAG_W-1:0]             tag_q;
  logic [sacrr_pkg::DATA_W-1:0] data_q;

  // memory rows
  logic [WAYS-1:0][TAG_W:0]               tag_row;
  logic [WAYS-1:0][TAG_W:0]               new_row;
  logic [WAYS-1:0][sacrr_pkg::DATA_W-1:0] data_row;
  logic [IDX_W-1:0]                       rd_idx;
  logic [IDX_W-1:0]                       wr_idx;

  // lookup
  logic [SETS-1:0]  row_valid_q;
  logic             row_ok;
  logic [WAYS-1:0]  vld;
  logic [WAYS-1:0]  match;
  logic             hit_any;
  logic             inv_any;
  logic [WAY_W-1:0] hit_way;
  logic [WAY_W-1:0] inv_way;
  logic [WAY_W-1:0] victim;
  logic [WAY_W-1:0] last_alloc_q;
  logic             alloc;
  logic             data_we;
  logic [WAY_W-1:0] data_lane;

  // result
  logic                         res_hit;
  logic [WAY_W-1:0]             res_way;
  logic                         res_evicted;
  logic [sacrr_pkg::DATA_W-1:0] res_rdata;
  logic                         hit_q;
  logic [WAY_W-1:0]             way_q;
  logic                         evicted_q;
  logic [sacrr_pkg::DATA_W-1:0] rdata_q;

  // config and lfsr
  logic [sacrr_pkg::LFSR_W-1:0] seed_q;
  logic [sacrr_pkg::LFSR_W-1:0] lfsr_next;
  sacrr_pkg::lfsr_ctrl_t        lfsr_ctrl;

  // handshake
  assign in_accept  = in_valid_i && !busy_q;
  assign in_stall_o = busy_q;
  assign complete   = busy_q && (!out_valid_q || !out_stall_i);

  // address split
  assign addr_m  = address_i & ADDR_MASK;
  assign set_in  = SET_BITS'(addr_m >> (2 + OFF_BITS));
  assign word_in = WORD_W'((addr_m >> 2) & WORD_MASK);
  assign tag_in  = TAG_W'(addr_m >> TAG_SHIFT);
  assign rd_idx  = (IDX_W'(set_in) << OFF_BITS) | IDX_W'(word_in);
  assign wr_idx  = (IDX_W'(set_q) << OFF_BITS) | IDX_W'(word_q);

  // busy flag: set on accept, cleared on write-back
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (in_accept) begin
      busy_q <= 1'b1;
    end else if (complete) begin
      busy_q <= 1'b0;
    end
  end

  // capture the accepted word
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      kind_q <= kind_i;
      set_q  <= set_in;
      word_q <= word_in;
      tag_q  <= tag_in;
      data_q <= data_i;
    end
  end

  // tag compare and way search
  always_comb begin
    row_ok  = row_valid_q[set_q];
    vld     = '0;
    match   = '0;
    hit_way = '0;
    inv_way = '0;
    for (int w = 0; w < WAYS; w++) begin
      vld[w]   = row_ok && tag_row[w][TAG_W];
      match[w] = vld[w] && (tag_row[w][TAG_W-1:0] == tag_q);
      if (match[w]) begin
        hit_way = WAY_W'(w);
      end
      if (!vld[w]) begin
        inv_way = WAY_W'(w);
      end
    end
    hit_any = |match;
    inv_any = ~&vld;
    victim  = inv_any ? inv_way : WAY_W'(lfsr_next & WAY_MASK);
  end

  // result and write-back decisions per kind
  always_comb begin
    res_hit     = 1'b0;
    res_way     = '0;
    res_evicted = 1'b0;
    res_rdata   = '0;
    alloc       = 1'b0;
    data_we     = 1'b0;
    data_lane   = hit_way;
    unique case (kind_q) inside
      sacrr_pkg::KIND_READ, sacrr_pkg::KIND_WRITE: begin
        if (hit_any) begin
          res_hit = 1'b1;
          res_way = hit_way;
          if (kind_q == sacrr_pkg::KIND_READ) begin
            res_rdata = data_row[hit_way];
          end else begin
            data_we = 1'b1;
          end
        end else begin
          alloc       = 1'b1;
          res_way     = victim;
          res_evicted = !inv_any;
        end
      end
      sacrr_pkg::KIND_REFILL: begin
        data_we   = 1'b1;
        data_lane = last_alloc_q;
        res_way   = last_alloc_q;
      end
      default: begin
      end
    endcase
  end

  // new tag row: keep qualified valid bits, install the victim
  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      new_row[w] = {vld[w], tag_row[w][TAG_W-1:0]};
    end
    new_row[victim] = {1'b1, tag_q};
  end

  // per-set row valid flags and last allocated way
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_valid_q  <= '0;
      last_alloc_q <= '0;
    end else if (complete && alloc) begin
      row_valid_q[set_q] <= 1'b1;
      last_alloc_q       <= victim;
    end
  end

  sacrr_tag_store #(
    .SETS  (SETS),
    .WAYS  (WAYS),
    .TAG_W (TAG_W)
  ) u_tag_store (
    .clk_i    (clk_i),
    .rd_en_i  (in_accept),
    .rd_set_i (set_in),
    .rd_row_o (tag_row),
    .wr_en_i  (complete && alloc),
    .wr_set_i (set_q),
    .wr_row_i (new_row)
  );

  sacrr_data_store #(
    .DEPTH (DEPTH),
    .WAYS  (WAYS)
  ) u_data_store (
    .clk_i     (clk_i),
    .rd_en_i   (in_accept),
    .rd_idx_i  (rd_idx),
    .rd_row_o  (data_row),
    .wr_en_i   (complete && data_we),
    .wr_idx_i  (wr_idx),
    .wr_lane_i (data_lane),
    .wr_data_i (data_q)
  );

  // victim lfsr: steps only when a miss finds every way valid
  assign lfsr_ctrl.load = cfg_we;
  assign lfsr_ctrl.step = complete && alloc && !inv_any;
  assign lfsr_ctrl.seed = pwdata[sacrr_pkg::LFSR_W-1:0];

  sacrr_lfsr u_lfsr (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (lfsr_ctrl),
    .next_o (lfsr_next)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (complete) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (complete) begin
      hit_q     <= res_hit;
      way_q     <= res_way;
      evicted_q <= res_evicted;
      rdata_q   <= res_rdata;
    end
  end

  assign out_valid_o = out_valid_q;
  assign hit_o       = hit_q;
  assign way_o       = sacrr_pkg::WAY_OUT_W'(way_q);
  assign evicted_o   = evicted_q;
  assign read_data_o = rdata_q;

  // configuration register
  assign cfg_we = psel && penable && pwrite && pready &&
                  (paddr[2] == sacrr_pkg::REG_RANDOM_SEED);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= sacrr_pkg::SEED_RESET;
    end else if (cfg_we) begin
      seed_q <= pwdata[sacrr_pkg::LFSR_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == sacrr_pkg::REG_RANDOM_SEED) ?
                  sacrr_pkg::DATA_W'(seed_q) : '0;

endmodule

/* rtl/core/sacrr_checker.sv */
// Port checker for the cache top level, attached by bind.
// Uses the assertion macros header and sacrr_pkg for port widths.
`timescale 1ns / 1ps
`include "set_assoc_cache_random_replace_assert.svh"

module sacrr_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_stall_o,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic                         hit_o,
  input logic                         evicted_o,
  input logic [sacrr_pkg::DATA_W-1:0] read_data_o
);

  // a stalled result stays offered
  `SACRR_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o)

  // lookup and write-back interlock: no word taken right after another
  `SACRR_ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o)

  // a hit never reports an eviction
  `SACRR_ASSERT_IMPL(a_hit_no_evict, out_valid_o && hit_o, !evicted_o)

  // read data is zero unless the word hit
  `SACRR_ASSERT_IMPL(a_miss_zero_data, out_valid_o && !hit_o, read_data_o == '0)

endmodule

bind set_assoc_cache_random_replace sacrr_checker u_sacrr_checker (.*);
